/* hdl/kstt_pkg.sv */
package kstt_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);
	localparam logic [31:0] TICK_STEP = 32'd10;
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_SET = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_BAD = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_FIRE = 2'd1,
		KIND_TICK_DONE = 2'd2
	} kind_t;

	// command handed from the front end to the table engine
	typedef struct packed {
		action_t action;
		logic [7:0] dest_task;
		logic [15:0] signal_code;
		logic periodic;
		logic [31:0] duty;
		logic reject;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic status;
		logic [7:0] fire_task;
		logic [15:0] fire_signal;
		logic [31:0] system_tick;
		logic last;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT,
		ST_DONE
	} state_t;

endpackage

/* hdl/kstt_front.sv */
module kstt_front
	import kstt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [58:0] in_data,
	output logic q_valid,
	input logic q_ready,
	output cmd_t q_cmd
);

	cmd_t mem_q [QDEPTH];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t cmd;
	logic push;
	logic pop;

	// classify: duty below one step and unused action are rejected up front
	always_comb begin
		cmd.action = action_t'(in_data[1:0]);
		cmd.dest_task = in_data[9:2];
		cmd.signal_code = in_data[25:10];
		cmd.periodic = in_data[26];
		cmd.duty = in_data[58:27];
		cmd.reject = (cmd.action == ACT_BAD) ||
			(cmd.action == ACT_SET && cmd.duty < TICK_STEP);
	end

	assign in_ready = cnt_q != 2'(QDEPTH);
	assign push = in_valid && in_ready;
	assign q_valid = cnt_q != 2'd0;
	assign pop = q_valid && q_ready;
	assign q_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

/* hdl/kstt_engine.sv */
module kstt_engine
	import kstt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input cmd_t q_cmd,
	output logic out_valid,
	input logic out_ready,
	output res_t out_res
);

	state_t state_q;
	state_t state_nxt;
	cmd_t cmd_q;
	logic [SLOT_W-1:0] idx_q;
	logic [NUM_SLOTS-1:0] valid_q;
	logic [7:0] task_q [NUM_SLOTS];
	logic [15:0] sig_q [NUM_SLOTS];
	logic per_q [NUM_SLOTS];
	logic [31:0] count_q [NUM_SLOTS];
	logic [31:0] period_q [NUM_SLOTS];
	logic [31:0] tick_q;
	logic hit_q;
	logic [SLOT_W-1:0] hit_idx_q;
	logic free_q;
	logic [SLOT_W-1:0] free_idx_q;
	logic [SLOT_W-1:0] i;
	logic [31:0] dec;
	logic match;
	logic fire;
	logic scan_end;
	res_t res_q;
	logic res_valid_q;
	logic res_free;
	logic res_load;

	assign i = idx_q;
	assign dec = (count_q[i] > TICK_STEP) ? count_q[i] - TICK_STEP : 32'd0;
	assign match = valid_q[i] && task_q[i] == cmd_q.dest_task &&
		sig_q[i] == cmd_q.signal_code;
	assign fire = cmd_q.action == ACT_TICK && valid_q[i] && dec == 32'd0;
	assign scan_end = idx_q == SLOT_W'(NUM_SLOTS - 1);
	assign res_free = !res_valid_q || out_ready;
	assign res_load = (state_q == ST_EMIT || state_q == ST_DONE) && res_free;
	assign out_valid = res_valid_q;
	assign out_res = res_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					state_nxt = q_cmd.reject ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (fire) begin
					state_nxt = ST_EMIT;
				end else if (scan_end) begin
					state_nxt = ST_DONE;
				end
			end
			ST_EMIT: begin
				if (res_free) begin
					state_nxt = scan_end ? ST_DONE : ST_SCAN;
				end
			end
			ST_DONE: begin
				if (res_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		q_ready = state_q == ST_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			tick_q <= 32'd0;
			res_valid_q <= 1'b0;
			idx_q <= '0;
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			free_q <= 1'b0;
			free_idx_q <= '0;
		end else begin
			state_q <= state_nxt;
			res_valid_q <= res_load || (res_valid_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					hit_q <= 1'b0;
					free_q <= 1'b0;
					if (q_valid && !q_cmd.reject && q_cmd.action == ACT_TICK) begin
						tick_q <= tick_q + TICK_STEP;
					end
				end
				ST_SCAN: begin
					if (cmd_q.action == ACT_TICK) begin
						if (fire && !per_q[i]) begin
							valid_q[i] <= 1'b0;
						end
					end else begin
						if (match && !hit_q) begin
							hit_q <= 1'b1;
							hit_idx_q <= i;
						end
						if (!valid_q[i] && !free_q) begin
							free_q <= 1'b1;
							free_idx_q <= i;
						end
					end
					if (!fire && !scan_end) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (res_free && !scan_end) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (res_free) begin
						if (!cmd_q.reject) begin
							if (cmd_q.action == ACT_SET && !hit_q && free_q) begin
								valid_q[free_idx_q] <= 1'b1;
							end
							if (cmd_q.action == ACT_REMOVE && hit_q) begin
								valid_q[hit_idx_q] <= 1'b0;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			cmd_q <= q_cmd;
		end
		if (state_q == ST_SCAN && cmd_q.action == ACT_TICK && valid_q[i]) begin
			count_q[i] <= (fire && per_q[i]) ? period_q[i] : dec;
		end
		if (state_q == ST_EMIT && res_free) begin
			res_q.kind <= KIND_FIRE;
			res_q.status <= 1'b0;
			res_q.fire_task <= task_q[i];
			res_q.fire_signal <= sig_q[i];
			res_q.system_tick <= tick_q;
			res_q.last <= 1'b0;
		end
		if (state_q == ST_DONE && res_free) begin
			res_q.fire_task <= 8'd0;
			res_q.fire_signal <= 16'd0;
			res_q.system_tick <= tick_q;
			res_q.last <= 1'b1;
			if (cmd_q.reject) begin
				res_q.kind <= KIND_STATUS;
				res_q.status <= 1'b1;
			end else if (cmd_q.action == ACT_TICK) begin
				res_q.kind <= KIND_TICK_DONE;
				res_q.status <= 1'b0;
			end else begin
				res_q.kind <= KIND_STATUS;
				res_q.status <= cmd_q.action == ACT_SET && !hit_q && !free_q;
			end
			if (!cmd_q.reject && cmd_q.action == ACT_SET) begin
				if (hit_q) begin
					count_q[hit_idx_q] <= cmd_q.duty;
				end else if (free_q) begin
					task_q[free_idx_q] <= cmd_q.dest_task;
					sig_q[free_idx_q] <= cmd_q.signal_code;
					per_q[free_idx_q] <= cmd_q.periodic;
					count_q[free_idx_q] <= cmd_q.duty;
					period_q[free_idx_q] <= cmd_q.periodic ? cmd_q.duty : 32'd0;
				end
			end
		end
	end

endmodule

/* hdl/keyed_soft_timer_table.sv */
// Keyed timer table: NUM_SLOTS one-shot or periodic timers keyed by (task, signal).
// Commands enter a two-deep queue and a table engine walks the slots one per cycle,
// pausing on a firing slot until its fire event is loaded into the result register,
// and a rejected command (short duty or unused action) skips the walk. The engine
// also waits while a stalled output holds the result register.
// A tick yields fire events in slot order followed by a tick-complete transfer;
// set and remove yield one status transfer. The input queue lets further
// commands be taken while the engine works or a result waits.
module keyed_soft_timer_table
	import kstt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [63:0] s_axis_tdata, // action, dest_task, signal_code, periodic, duty
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [63:0] m_axis_tdata, // kind, status, fire_task, fire_signal, system_tick
	output logic m_axis_tlast
);

	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;
	res_t res;

	kstt_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_data(s_axis_tdata[58:0]),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_cmd(q_cmd)
	);

	kstt_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_cmd(q_cmd),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res(res)
	);

	assign m_axis_tdata = {5'd0, res.system_tick, res.fire_signal, res.fire_task,
		res.status, res.kind};
	assign m_axis_tlast = res.last;

endmodule

/* sim/keyed_soft_timer_table_tb.sv */
`timescale 1ns / 100ps

module keyed_soft_timer_table_tb;
	import kstt_pkg::*;

	localparam int WATCHDOG_CYCLES = 20000;

	// first field in the lowest bits, as on tdata
	typedef struct packed {
		logic [31:0] duty;
		logic periodic;
		logic [15:0] signal_code;
		logic [7:0] dest_task;
		action_t action;
	} timer_cmd_t;

	typedef struct packed {
		logic last;
		logic [31:0] system_tick;
		logic [15:0] fire_signal;
		logic [7:0] fire_task;
		logic status;
		kind_t kind;
	} timer_res_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic m_axis_tlast;

	keyed_soft_timer_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	// shadow timer table
	logic tmr_valid [NUM_SLOTS];
	logic [7:0] tmr_task [NUM_SLOTS];
	logic [15:0] tmr_signal [NUM_SLOTS];
	logic tmr_periodic [NUM_SLOTS];
	logic [31:0] tmr_count [NUM_SLOTS];
	logic [31:0] tmr_period [NUM_SLOTS];
	logic [31:0] tick_sum;

	timer_cmd_t pending_cmds[$];
	timer_res_t expected_events[$];
	int error_count;
	int idle_cycles;
	bit stimulus_done;
	bit calm;           // no random idling
	int hold_off;       // receiver hold-off cycles left
	bit hold_request;
	bit in_taken;       // input transfer at the last rising edge

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic timer_res_t make_res(kind_t k, logic st, logic [7:0] t,
		logic [15:0] s, logic l);
		timer_res_t r;
		r.kind = k;
		r.status = st;
		r.fire_task = t;
		r.fire_signal = s;
		r.system_tick = tick_sum;
		r.last = l;
		return r;
	endfunction

	function automatic int lookup_key(logic [7:0] t, logic [15:0] s);
		for (int i = 0; i < NUM_SLOTS; i++)
			if (tmr_valid[i] && tmr_task[i] == t && tmr_signal[i] == s)
				return i;
		return -1;
	endfunction

	task automatic predict_timers(timer_cmd_t c);
		int slot;
		slot = -1;
		case (c.action)
			ACT_TICK: begin
				tick_sum = tick_sum + TICK_STEP;
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (tmr_valid[i]) begin
						tmr_count[i] = (tmr_count[i] > TICK_STEP) ? tmr_count[i] - TICK_STEP : 32'd0;
						if (tmr_count[i] == 0) begin
							expected_events.push_back(make_res(KIND_FIRE, 1'b0, tmr_task[i],
								tmr_signal[i], 1'b0));
							if (tmr_periodic[i])
								tmr_count[i] = tmr_period[i];
							else
								tmr_valid[i] = 1'b0;
						end
					end
				end
				expected_events.push_back(make_res(KIND_TICK_DONE, 1'b0, 8'd0, 16'd0, 1'b1));
			end
			ACT_SET: begin
				if (c.duty < TICK_STEP) begin
					expected_events.push_back(make_res(KIND_STATUS, 1'b1, 8'd0, 16'd0, 1'b1));
				end else begin
					slot = lookup_key(c.dest_task, c.signal_code);
					if (slot >= 0) begin
						tmr_count[slot] = c.duty;
					end else begin
						for (int i = 0; i < NUM_SLOTS && slot < 0; i++)
							if (!tmr_valid[i])
								slot = i;
						if (slot >= 0) begin
							tmr_valid[slot] = 1'b1;
							tmr_task[slot] = c.dest_task;
							tmr_signal[slot] = c.signal_code;
							tmr_periodic[slot] = c.periodic;
							tmr_count[slot] = c.duty;
							tmr_period[slot] = c.periodic ? c.duty : 32'd0;
						end
					end
					expected_events.push_back(make_res(KIND_STATUS, slot < 0, 8'd0, 16'd0, 1'b1));
				end
			end
			ACT_REMOVE: begin
				slot = lookup_key(c.dest_task, c.signal_code);
				if (slot >= 0)
					tmr_valid[slot] = 1'b0;
				expected_events.push_back(make_res(KIND_STATUS, 1'b0, 8'd0, 16'd0, 1'b1));
			end
			default: begin
				expected_events.push_back(make_res(KIND_STATUS, 1'b1, 8'd0, 16'd0, 1'b1));
			end
		endcase
	endtask

	function automatic timer_cmd_t mk_cmd(action_t a, logic [7:0] t, logic [15:0] s,
		logic p, logic [31:0] d);
		timer_cmd_t c;
		c.action = a;
		c.dest_task = t;
		c.signal_code = s;
		c.periodic = p;
		c.duty = d;
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_taken <= 1'b0;
		else
			in_taken <= s_axis_tvalid && s_axis_tready;
	end

	// driver: changes inputs on the falling edge
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (in_taken) begin
				predict_timers(timer_cmd_t'(s_axis_tdata[58:0]));
				void'(pending_cmds.pop_front());
			end
			if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= 25)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {5'd0, pending_cmds[0]};
			end else if (!(s_axis_tvalid && !in_taken)) begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver ready, including the long hold-off
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_off <= 0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_request) begin
			hold_off <= 400;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || $urandom_range(99) >= 25;
		end
	end

	// monitor: samples at the rising edge
	always @(posedge clk) begin
		timer_res_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = timer_res_t'({m_axis_tlast, m_axis_tdata[58:0]});
			if (expected_events.size() == 0) begin
				$display("%0t: unexpected transfer %h", $time, got);
				error_count++;
			end else begin
				want = expected_events.pop_front();
				if (got.kind != want.kind) begin
					$display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
					error_count++;
				end
				if (got.status != want.status) begin
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
					error_count++;
				end
				if (got.fire_task != want.fire_task) begin
					$display("%0t: fire_task exp %h got %h", $time, want.fire_task,
						got.fire_task);
					error_count++;
				end
				if (got.fire_signal != want.fire_signal) begin
					$display("%0t: fire_signal exp %h got %h", $time, want.fire_signal,
						got.fire_signal);
					error_count++;
				end
				if (got.system_tick != want.system_tick) begin
					$display("%0t: system_tick exp %h got %h", $time, want.system_tick,
						got.system_tick);
					error_count++;
				end
				if (got.last != want.last) begin
					$display("%0t: last exp %0d got %0d", $time, want.last, got.last);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || expected_events.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		logic [7:0] t;
		logic [15:0] s;
		int pick;
		arst_n = 1'b0;
		error_count = 0;
		calm = 1'b0;
		hold_request = 1'b0;
		tick_sum = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			tmr_valid[i] = 1'b0;
			tmr_task[i] = '0;
			tmr_signal[i] = '0;
			tmr_periodic[i] = 1'b0;
			tmr_count[i] = '0;
			tmr_period[i] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: duty limits, reload, full table, removes, bad action, saturation
		pending_cmds.push_back(mk_cmd(ACT_TICK, 8'd0, 16'd0, 1'b0, 32'd0));
		pending_cmds.push_back(mk_cmd(ACT_SET, 8'hff, 16'hffff, 1'b1, 32'd9));
		pending_cmds.push_back(mk_cmd(ACT_SET, 8'hff, 16'hffff, 1'b1, TICK_STEP));
		pending_cmds.push_back(mk_cmd(ACT_SET, 8'h00, 16'h0000, 1'b0, 32'hffffffff));
		pending_cmds.push_back(mk_cmd(ACT_SET, 8'h00, 16'h0000, 1'b1, 32'd15));
		pending_cmds.push_back(mk_cmd(ACT_TICK, 8'd0, 16'd0, 1'b0, 32'd0));
		pending_cmds.push_back(mk_cmd(ACT_TICK, 8'd0, 16'd0, 1'b0, 32'd0));
		pending_cmds.push_back(mk_cmd(ACT_REMOVE, 8'h12, 16'h3456, 1'b0, 32'd0));
		pending_cmds.push_back(mk_cmd(ACT_BAD, 8'haa, 16'h5555, 1'b1, 32'd100));
		for (int i = 0; i < 16; i++)
			pending_cmds.push_back(mk_cmd(ACT_SET, 8'(i + 1), 16'(i * 7), i[0], 32'd20 + i));
		pending_cmds.push_back(mk_cmd(ACT_TICK, 8'd0, 16'd0, 1'b0, 32'd0));
		pending_cmds.push_back(mk_cmd(ACT_REMOVE, 8'hff, 16'hffff, 1'b0, 32'd0));
		wait_drained();

		// receiver stalls while the sender keeps offering
		hold_request = 1'b1;
		while (hold_off == 0)
			@(posedge clk);
		hold_request = 1'b0;
		for (int i = 0; i < 12; i++)
			pending_cmds.push_back(mk_cmd(ACT_TICK, 8'd0, 16'd0, 1'b0, 32'd0));
		wait_drained();

		// random: mostly sets, ticks and removes on a small key pool
		for (int n = 0; n < 300; n++) begin
			if (n == 100)
				calm = 1'b1;
			if (n == 160)
				calm = 1'b0;
			t = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
			s = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(5));
			pick = $urandom_range(99);
			if (pick < 40)
				pending_cmds.push_back(mk_cmd(ACT_TICK, 8'($urandom), 16'($urandom),
					1'($urandom), $urandom));
			else if (pick < 75)
				pending_cmds.push_back(mk_cmd(ACT_SET, t, s, 1'($urandom),
					($urandom_range(9) == 0) ? $urandom :
					32'($urandom_range(TICK_STEP * 6, 0))));
			else if (pick < 97)
				pending_cmds.push_back(mk_cmd(ACT_REMOVE, t, s, 1'($urandom), $urandom));
			else
				pending_cmds.push_back(mk_cmd(ACT_BAD, t, s, 1'($urandom), $urandom));
			if (pending_cmds.size() > 8)
				while (pending_cmds.size() > 4)
					@(posedge clk);
		end
		wait_drained();
		repeat (50) @(posedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
